@@ hdl/dtg_pkg.sv @@
`default_nettype none

package dtg_pkg;

  // character and slot geometry
  localparam int unsigned CharW       = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PackedSlots = 4;
  localparam int unsigned SlotIdxW    = 2;
  localparam int unsigned CountW      = 3;
  localparam int unsigned AsciiLimit  = 128;

  // parameter defaults
  localparam int unsigned MaxDelimsDef = 4;
  localparam int unsigned MaxGroupsDef = 4;

  // job queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // register port
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  typedef enum logic [2:0] {
    RegDelimChars = 3'd0,
    RegDelimCount = 3'd1,
    RegOpenChars  = 3'd2,
    RegCloseChars = 3'd3,
    RegGroupCount = 3'd4
  } dtg_reg_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } dtg_in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             token_end;
    logic             last_of_run;
  } dtg_out_t;

  typedef struct packed {
    logic [CharW*PackedSlots-1:0] delim_chars;
    logic [CountW-1:0]            delim_count;
    logic [CharW*PackedSlots-1:0] open_chars;
    logic [CharW*PackedSlots-1:0] close_chars;
    logic [CountW-1:0]            group_count;
  } dtg_cfg_t;

  // one classified character: the results it causes, in emission order
  typedef struct packed {
    logic             end_pre;
    logic             hi_byte;
    logic             lo_byte;
    logic             end_post;
  } dtg_pieces_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    dtg_pieces_t      pieces;
  } dtg_job_t;

endpackage

`default_nettype wire

@@ hdl/dtg_regs.sv @@
`default_nettype none

module dtg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [dtg_pkg::AddrW-1:0] paddr,
  input  wire logic [dtg_pkg::DataW-1:0] pwdata,
  output logic      [dtg_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output dtg_pkg::dtg_cfg_t              cfg_o
);
  import dtg_pkg::*;

  dtg_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  dtg_reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = dtg_reg_e'(paddr[AddrW-1:3]);

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegDelimChars: cfg_d.delim_chars = pwdata;
        RegDelimCount: cfg_d.delim_count = pwdata[CountW-1:0];
        RegOpenChars:  cfg_d.open_chars  = pwdata;
        RegCloseChars: cfg_d.close_chars = pwdata;
        RegGroupCount: cfg_d.group_count = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegDelimChars: prdata = cfg_q.delim_chars;
      RegDelimCount: prdata = DataW'(cfg_q.delim_count);
      RegOpenChars:  prdata = cfg_q.open_chars;
      RegCloseChars: prdata = cfg_q.close_chars;
      RegGroupCount: prdata = DataW'(cfg_q.group_count);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/dtg_front.sv @@
`default_nettype none

module dtg_front #(
  parameter int unsigned MaxDelims = dtg_pkg::MaxDelimsDef,
  parameter int unsigned MaxGroups = dtg_pkg::MaxGroupsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dtg_pkg::dtg_cfg_t cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dtg_pkg::dtg_in_t  in_data_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output dtg_pkg::dtg_job_t      q_job_o
);
  import dtg_pkg::*;

  localparam int unsigned NumD = (MaxDelims < PackedSlots) ? MaxDelims : PackedSlots;
  localparam int unsigned NumG = (MaxGroups < PackedSlots) ? MaxGroups : PackedSlots;

  logic                inside_q, inside_d;
  logic [SlotIdxW-1:0] slot_q, slot_d;
  logic                after_delim_q, after_delim_d;
  logic                tok_q, tok_d;

  logic                accept;
  logic [CharW-1:0]    ch;
  logic                delim_hit;
  logic                open_hit;
  logic [SlotIdxW-1:0] open_idx;
  logic                is_close;
  logic                emit;
  dtg_pieces_t         pieces;

  assign ch         = in_data_i.char_code;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // delimiter and group opener match, lowest slot in use wins
  always_comb begin
    delim_hit = 1'b0;
    open_hit  = 1'b0;
    open_idx  = '0;
    for (int i = 0; i < NumD; i++) begin
      if ((CountW'(i) < cfg_i.delim_count) && (cfg_i.delim_chars[i*CharW +: CharW] == ch)) begin
        delim_hit = 1'b1;
      end
    end
    for (int i = 0; i < NumG; i++) begin
      if (!open_hit && (CountW'(i) < cfg_i.group_count) &&
          (cfg_i.open_chars[i*CharW +: CharW] == ch)) begin
        open_hit = 1'b1;
        open_idx = SlotIdxW'(i);
      end
    end
  end

  // closer of the open pair
  assign is_close = (cfg_i.close_chars[{slot_q, 4'b0000} +: CharW] == ch);

  // classify the character and work out the next state
  always_comb begin
    inside_d      = inside_q;
    slot_d        = slot_q;
    after_delim_d = after_delim_q;
    tok_d         = tok_q;
    pieces        = '0;
    emit          = 1'b0;
    if (!inside_q) begin
      pieces.end_pre = delim_hit && !after_delim_q;
      after_delim_d  = delim_hit;
      if (pieces.end_pre) begin
        tok_d = 1'b0;
      end
      if (open_hit) begin
        inside_d      = 1'b1;
        slot_d        = open_idx;
        after_delim_d = 1'b1;
      end else begin
        emit = !delim_hit;
      end
    end else begin
      if (is_close) begin
        pieces.end_pre = 1'b1;
        tok_d          = 1'b0;
        inside_d       = 1'b0;
        slot_d         = '0;
      end else begin
        emit = 1'b1;
      end
    end
    if (emit) begin
      pieces.hi_byte = (ch >= CharW'(AsciiLimit));
      pieces.lo_byte = 1'b1;
      tok_d          = 1'b1;
    end
    // end of string: flush a token with bytes and start over
    if (in_data_i.last_char) begin
      pieces.end_post = tok_d;
      inside_d        = 1'b0;
      slot_d          = '0;
      after_delim_d   = 1'b0;
      tok_d           = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q      <= 1'b0;
      slot_q        <= '0;
      after_delim_q <= 1'b0;
      tok_q         <= 1'b0;
    end else if (accept) begin
      inside_q      <= inside_d;
      slot_q        <= slot_d;
      after_delim_q <= after_delim_d;
      tok_q         <= tok_d;
    end
  end

  // only characters with results go to the queue
  assign q_push_o          = accept && (pieces != '0);
  assign q_job_o.char_code = ch;
  assign q_job_o.pieces    = pieces;

endmodule

`default_nettype wire

@@ hdl/dtg_job_fifo.sv @@
`default_nettype none

module dtg_job_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dtg_pkg::dtg_job_t push_job_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output dtg_pkg::dtg_job_t      head_o,
  output logic                   empty_o
);
  import dtg_pkg::*;

  dtg_job_t         mem_q [QDepth];
  logic [QAw-1:0]   wptr_q, rptr_q;
  logic [QAw:0]     count_q, count_d;

  assign full_o  = (count_q == (QAw+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  // occupancy
  always_comb begin
    count_d = count_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dtg_back.sv @@
`default_nettype none

module dtg_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dtg_pkg::dtg_job_t head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dtg_pkg::dtg_out_t      out_data_o
);
  import dtg_pkg::*;

  dtg_job_t    cur_q, cur_d;
  logic        ov_q, ov_d;
  dtg_out_t    out_q, out_d;

  logic        adv;
  logic        use_cur;
  dtg_job_t    src;
  dtg_pieces_t rem;

  assign adv     = !ov_q || out_ready_i;
  assign use_cur = (cur_q.pieces != '0);
  assign src     = use_cur ? cur_q : head_i;

  // send the earliest piece left in the current word
  always_comb begin
    cur_d = cur_q;
    ov_d  = ov_q;
    out_d = out_q;
    pop_o = 1'b0;
    rem   = src.pieces;
    if (adv) begin
      ov_d = 1'b0;
      if (use_cur || !empty_i) begin
        out_d = '0;
        priority if (src.pieces.end_pre) begin
          rem.end_pre     = 1'b0;
          out_d.token_end = 1'b1;
        end else if (src.pieces.hi_byte) begin
          rem.hi_byte      = 1'b0;
          out_d.out_byte   = src.char_code[CharW-1 -: ByteW];
          out_d.byte_valid = 1'b1;
        end else if (src.pieces.lo_byte) begin
          rem.lo_byte      = 1'b0;
          out_d.out_byte   = src.char_code[ByteW-1:0];
          out_d.byte_valid = 1'b1;
        end else begin
          rem.end_post    = 1'b0;
          out_d.token_end = 1'b1;
        end
        out_d.last_of_run = (rem == '0);
        cur_d.char_code   = src.char_code;
        cur_d.pieces      = rem;
        ov_d              = 1'b1;
        pop_o             = !use_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      ov_q  <= 1'b0;
      out_q <= '0;
    end else begin
      cur_q <= cur_d;
      ov_q  <= ov_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/delimiter_tokenizer_with_groups.sv @@
`default_nettype none

// channel   direction  handshake                 word
// in        input      in_valid_i / in_ready_o   dtg_in_t  (char_code, last_char)
// out       output     out_valid_o / out_ready_i dtg_out_t (one token byte or token end)
// cfg       input      apb psel/penable/pwrite   64-bit registers at 8*index
//
// the front classifies one character per cycle while the queue has room and queues a
// job if it has results; the back sends one result per cycle while out_ready_i is high:
// one for an ascii character, two for a two-byte character, plus one per token end, so
// a character causes 0 to 3 results; the back's single output register sets the rate;
// a 4-deep job queue lets the front keep taking characters while a result waits
// reset clears the tokenizer state, the queue and the registers; no clearing pass

module delimiter_tokenizer_with_groups #(
  parameter int unsigned MAX_DELIMS = dtg_pkg::MaxDelimsDef,
  parameter int unsigned MAX_GROUPS = dtg_pkg::MaxGroupsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire dtg_pkg::dtg_in_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output dtg_pkg::dtg_out_t              out_data_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [dtg_pkg::AddrW-1:0] paddr,
  input  wire logic [dtg_pkg::DataW-1:0] pwdata,
  output logic      [dtg_pkg::DataW-1:0] prdata,
  output logic                           pready
);
  import dtg_pkg::*;

  dtg_cfg_t cfg;
  logic     q_push, q_full, q_pop, q_empty;
  dtg_job_t q_job, q_head;

  // configuration registers
  dtg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // classify characters
  dtg_front #(
    .MaxDelims (MAX_DELIMS),
    .MaxGroups (MAX_GROUPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  // job queue
  dtg_job_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  // serialize results
  dtg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a result is a byte or a token end, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_valid != out_data_o.token_end))
    else $error("result carries both or neither of byte and token end");

  // token ends carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.byte_valid) |-> (out_data_o.out_byte == '0))
    else $error("token end with nonzero byte");

  // the back never takes from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty job queue");

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full job queue");

endmodule

`default_nettype wire

@@ bench/tb_delimiter_tokenizer_with_groups.sv @@
`timescale 1ns / 1ps

module tb_delimiter_tokenizer_with_groups;
  import dtg_pkg::*;

  // shadow of the tokenizer: registers, token state and the words still owed
  class tokenizer_shadow;
    dtg_out_t    owed_words[$];
    dtg_out_t    char_words[$];
    int          mismatches;
    logic [63:0] delim_chars, open_chars, close_chars;
    logic [2:0]  delim_count, group_count;
    bit          grouped, after_delim, has_bytes;
    logic [1:0]  group_slot;

    function void set_reg(dtg_reg_e idx, logic [63:0] v);
      case (idx)
        RegDelimChars: delim_chars = v;
        RegDelimCount: delim_count = v[2:0];
        RegOpenChars:  open_chars = v;
        RegCloseChars: close_chars = v;
        RegGroupCount: group_count = v[2:0];
        default: ;
      endcase
    endfunction

    function int slots_used(logic [2:0] cnt, int lim);
      int n;
      n = cnt;
      if (n > lim) n = lim;
      if (n > PackedSlots) n = PackedSlots;
      return n;
    endfunction

    // lowest slot in use holding the code, or -1
    function int find_slot(logic [63:0] packed_chars, int n, logic [15:0] ch);
      for (int i = 0; i < n; i++)
        if (packed_chars[i*16 +: 16] == ch) return i;
      return -1;
    endfunction

    function void put_word(logic [7:0] b, bit v, bit e);
      dtg_out_t w;
      w.out_byte = v ? b : 8'h00;
      w.byte_valid = v;
      w.token_end = e;
      w.last_of_run = 1'b0;
      char_words.push_back(w);
    endfunction

    function void put_char(logic [15:0] ch);
      if (ch < AsciiLimit) begin
        put_word(ch[7:0], 1'b1, 1'b0);
      end else begin
        put_word(ch[15:8], 1'b1, 1'b0);
        put_word(ch[7:0], 1'b1, 1'b0);
      end
      has_bytes = 1'b1;
    endfunction

    // work out the words one accepted character causes
    function void take_char(dtg_in_t w);
      int nd, ng, g;
      logic [15:0] ch;
      ch = w.char_code;
      nd = slots_used(delim_count, MaxDelimsDef);
      ng = slots_used(group_count, MaxGroupsDef);
      char_words.delete();
      if (!grouped) begin
        if (find_slot(delim_chars, nd, ch) >= 0) begin
          if (!after_delim) begin
            put_word(8'h00, 1'b0, 1'b1);
            has_bytes = 1'b0;
            after_delim = 1'b1;
          end
        end else begin
          after_delim = 1'b0;
        end
        g = find_slot(open_chars, ng, ch);
        if (g >= 0) begin
          // opener: nothing sent, current token stays open
          grouped = 1'b1;
          group_slot = g[1:0];
          after_delim = 1'b1;
        end else if (!after_delim) begin
          put_char(ch);
        end
      end else begin
        // inside a group only the matching closer is special
        if (ch == close_chars[group_slot*16 +: 16]) begin
          put_word(8'h00, 1'b0, 1'b1);
          has_bytes = 1'b0;
          grouped = 1'b0;
          group_slot = 2'd0;
        end else begin
          put_char(ch);
        end
      end
      // end of string flushes a token with bytes and clears the state
      if (w.last_char) begin
        if (has_bytes) put_word(8'h00, 1'b0, 1'b1);
        grouped = 1'b0;
        group_slot = 2'd0;
        after_delim = 1'b0;
        has_bytes = 1'b0;
      end
      if (char_words.size() > 0) char_words[char_words.size()-1].last_of_run = 1'b1;
      foreach (char_words[i]) owed_words.push_back(char_words[i]);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 60) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_word(dtg_out_t got);
      dtg_out_t want;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected word %h", got));
      end else begin
        want = owed_words.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.byte_valid !== want.byte_valid)
          report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
        if (got.token_end !== want.token_end)
          report($sformatf("token_end %b, want %b", got.token_end, want.token_end));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dtg_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dtg_out_t            out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  tokenizer_shadow shadow = new();
  int              in_taken = 0;
  int              out_taken = 0;
  bit              tx_burst = 1'b0;
  bit              rx_burst = 1'b0;

  always #6 clk_i = ~clk_i;

  delimiter_tokenizer_with_groups u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // handshake monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      shadow.take_char(in_data);
      in_taken++;
    end
    if (rst_ni && out_valid && out_ready) begin
      shadow.check_word(out_data);
      out_taken++;
    end
  end

  // receiver with random stalls and stall-free stretches
  initial begin
    int gap, seen;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 23) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      seen = out_taken;
      do @(negedge clk_i); while (out_taken == seen);
    end
  end

  task automatic reg_write(dtg_reg_e idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(8 * int'(idx));
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow.set_reg(idx, v);
  endtask

  task automatic load_config(logic [63:0] d, logic [2:0] dc, logic [63:0] o,
                             logic [63:0] c, logic [2:0] gc);
    reg_write(RegDelimChars, d);
    reg_write(RegDelimCount, 64'(dc));
    reg_write(RegOpenChars, o);
    reg_write(RegCloseChars, c);
    reg_write(RegGroupCount, 64'(gc));
  endtask

  // stop sending, wait for every owed word, then for any character that causes none
  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.owed_words.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send_char(logic [15:0] ch, bit last);
    int gap, seen;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: ch, last_char: last};
    seen = in_taken;
    do @(negedge clk_i); while (in_taken == seen);
  endtask

  function automatic logic [15:0] slot_char_rand();
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(32, 126));
    return 16'($urandom);
  endfunction

  // mostly configured codes and printable text, some wide and extreme codes
  function automatic logic [15:0] pick_char();
    int s;
    s = $urandom_range(0, 3);
    case ($urandom_range(0, 12))
      0, 1, 2: return shadow.delim_chars[s*16 +: 16];
      3:       return shadow.open_chars[s*16 +: 16];
      4, 5:    return shadow.close_chars[s*16 +: 16];
      6, 7, 8: return 16'($urandom_range(32, 126));
      9:       return 16'($urandom_range(0, 127));
      10, 11:  return 16'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic random_strings(int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      len = $urandom_range(1, 12);
      if (len > count - sent) len = count - sent;
      for (int i = 0; i < len; i++) begin
        // a few strings are cut off without an end mark
        send_char(pick_char(), (i == len - 1) && ($urandom_range(0, 7) != 0));
        sent++;
      end
    end
  endtask

  task automatic random_config();
    logic [63:0] d, o, c;
    for (int i = 0; i < 4; i++) begin
      d[i*16 +: 16] = slot_char_rand();
      o[i*16 +: 16] = slot_char_rand();
      c[i*16 +: 16] = ($urandom_range(0, 7) == 0) ? 16'h0000 : slot_char_rand();
    end
    load_config(d, 3'($urandom_range(0, 7)), o, c, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // space, comma, a wide code and all ones split; four pairs, one closed by zero
    load_config({16'hFFFF, 16'hC3A9, 16'h002C, 16'h0020}, 3'd4,
                {16'h8000, 16'h007B, 16'h0022, 16'h0028},
                {16'h0000, 16'h007D, 16'h0022, 16'h0029}, 3'd7);
    send_char(16'h0061, 1'b0);
    send_char(16'h007F, 1'b0);
    send_char(16'h0020, 1'b0);
    send_char(16'h0020, 1'b0);  // second delimiter in a row is silent
    send_char(16'h0080, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0028, 1'b0);  // open a group
    send_char(16'h0020, 1'b0);  // delimiter kept inside the group
    send_char(16'hC3A9, 1'b0);
    send_char(16'h0029, 1'b0);
    send_char(16'h0062, 1'b0);
    send_char(16'h0022, 1'b0);  // opener right after a byte keeps the token
    send_char(16'h0078, 1'b0);
    send_char(16'h0022, 1'b0);
    send_char(16'h8000, 1'b0);
    send_char(16'h0071, 1'b0);
    send_char(16'h0000, 1'b0);  // zero closer
    send_char(16'h007A, 1'b1);
    send_char(16'hABCD, 1'b1);  // two bytes plus the flush
    send_char(16'h002C, 1'b1);
    send_char(16'h0028, 1'b1);  // opener at the end causes nothing
    send_char(16'h0028, 1'b0);
    send_char(16'h0000, 1'b1);
    random_strings(90);
    drain();

    random_config();
    random_strings(90);
    drain();

    // extremes: code zero splits, all ones opens and closes its own group
    load_config(64'h0, 3'd1, {64{1'b1}}, {64{1'b1}}, 3'd4);
    random_strings(90);
    drain();

    // nothing in use: every code is sent as text
    load_config(64'h0020_002C_003B_003A, 3'd0, 64'h0028_005B_007B_0022,
                64'h0029_005D_007D_0022, 3'd0);
    random_strings(45);
    drain();

    random_config();
    random_strings(45);
    drain();

    if (shadow.mismatches == 0) begin
      $display("[delimiter_tokenizer_with_groups] OK");
    end else begin
      $display("[delimiter_tokenizer_with_groups] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[delimiter_tokenizer_with_groups] ERROR");
    $finish;
  end

endmodule
